>>> hw/rtl/tiled_int8_matmul_gelu_core_defines.svh
// Assertion macros for the tiled int8 matmul GELU core.
// Included by RTL files that carry concurrent assertions; no other dependencies.
`ifndef TILED_INT8_MATMUL_GELU_CORE_DEFINES_SVH
`define TILED_INT8_MATMUL_GELU_CORE_DEFINES_SVH
`ifndef SYNTH
`define TMG_ASSERT_IMPL(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define TMG_ASSERT_NEXT(label, clk, rst_n, a, b, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) else $error(msg);
`else
`define TMG_ASSERT_IMPL(label, clk, rst_n, prop, msg)
`define TMG_ASSERT_NEXT(label, clk, rst_n, a, b, msg)
`endif
`endif

>>> hw/rtl/tmg_pkg.sv
// Shared types and constants for the tiled int8 matmul GELU core.
// No dependencies.
`default_nettype none
package tmg_pkg;
    localparam int TILE      = 8;
    localparam int ELEMS     = TILE * TILE;
    localparam int IDX_W     = $clog2(ELEMS);
    localparam int POS_W     = (TILE > 1) ? $clog2(TILE) : 1;
    localparam int ROW_W     = 13;
    localparam logic [ROW_W-1:0] MAX_ROWS = 13'd4096;

    localparam logic [1:0] KIND_BIAS   = 2'd0;
    localparam logic [1:0] KIND_WEIGHT = 2'd1;
    localparam logic [1:0] KIND_ACT    = 2'd2;

    localparam logic [2:0] REG_GELU_B      = 3'd0;
    localparam logic [2:0] REG_GELU_C      = 3'd1;
    localparam logic [2:0] REG_GELU_SHIFT  = 3'd2;
    localparam logic [2:0] REG_SCALE_MULT  = 3'd3;
    localparam logic [2:0] REG_SCALE_SHIFT = 3'd4;
    localparam logic [2:0] REG_INNER_ROWS  = 3'd5;

    typedef struct packed {
        logic [31:0] gelu_b;
        logic [31:0] gelu_c;
        logic [31:0] gelu_shift;
        logic [31:0] scale_mult;
        logic [5:0]  scale_shift;
    } gelu_cfg_t;
endpackage
`default_nettype wire

>>> hw/rtl/tiled_int8_matmul_gelu_core.sv
// Top level of the tiled int8 matmul GELU core.
// Depends on tmg_pkg, tmg_ram, tmg_gelu and the assertion macro header.
//
// Usage: write registers on the cfg channel (cfg_valid/cfg_ready, cfg_index,
// cfg_data) only while the block is idle. Items arrive on start with kind,
// bias_value and data_byte; a transaction completes when start is high and
// busy is low. Per tile: 64 bias words, then inner_rows times 8 weight bytes
// and 8 activation bytes. Items of the wrong kind are dropped.
// A bias or weight item is taken without busy going high. After an
// activation is accepted, busy is high while the eight accumulators of the
// row are read through the single read port one per cycle, each updated and
// written back in the cycle after its read. After the last activation the
// block streams the 64 results, one per cycle through the memory read and
// the 7-stage GELU pipeline, strobed by out_valid; busy stays high until
// the last result has left. The receiver cannot stall. Reset returns to
// bias loading with counters cleared; accumulator contents are undefined
// until the bias words are written.
`default_nettype none
`include "tiled_int8_matmul_gelu_core_defines.svh"
module tiled_int8_matmul_gelu_core
    import tmg_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [1:0]  kind,
    input  wire logic [31:0] bias_value,
    input  wire logic [7:0]  data_byte,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [31:0] cfg_data,
    output logic             out_valid,
    output logic [7:0]       out_value,
    output logic [2:0]       out_row,
    output logic [2:0]       out_col,
    output logic             last
);
    localparam logic [2:0] ST_BIAS   = 3'd0;
    localparam logic [2:0] ST_WEIGHT = 3'd1;
    localparam logic [2:0] ST_ACT    = 3'd2;
    localparam logic [2:0] ST_MAC    = 3'd3;
    localparam logic [2:0] ST_EMIT   = 3'd4;
    localparam logic [2:0] ST_DRAIN  = 3'd5;

    gelu_cfg_t         cfg_reg;
    logic [ROW_W-1:0]  rows_reg;
    logic [2:0]        state_reg, state_next;
    logic [IDX_W-1:0]  cnt_reg, cnt_next;
    logic [ROW_W-1:0]  row_cnt_reg, row_cnt_next;
    logic [POS_W:0]    mac_reg, mac_next;
    logic [IDX_W:0]    emit_reg, emit_next;
    logic [7:0]        wrow_reg [TILE];
    logic [7:0]        act_reg;
    logic [POS_W-1:0]  arow_reg;
    logic              rd_vld_reg;
    logic [IDX_W-1:0]  rd_idx_reg;
    logic [3:0]        drain_reg;

    logic              accept;
    logic              mem_we;
    logic [IDX_W-1:0]  mem_wa, mem_ra;
    logic [31:0]       mem_wd, mem_rd;
    logic [ROW_W-1:0]  rows_eff;
    logic [15:0]       prod;
    logic              g_valid, g_last;
    logic [POS_W-1:0]  g_row, g_col;

    assign cfg_ready = 1'b1;
    assign busy      = (state_reg == ST_MAC) || (state_reg == ST_EMIT)
                       || (state_reg == ST_DRAIN);
    assign accept    = start && !busy;
    assign rows_eff  = (rows_reg == '0) ? 13'd1 : ((rows_reg > MAX_ROWS) ? MAX_ROWS : rows_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg  <= '0;
            rows_reg <= 13'd8;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_GELU_B:      cfg_reg.gelu_b      <= cfg_data;
                REG_GELU_C:      cfg_reg.gelu_c      <= cfg_data;
                REG_GELU_SHIFT:  cfg_reg.gelu_shift  <= cfg_data;
                REG_SCALE_MULT:  cfg_reg.scale_mult  <= cfg_data;
                REG_SCALE_SHIFT: cfg_reg.scale_shift <= cfg_data[5:0];
                REG_INNER_ROWS:  rows_reg            <= cfg_data[ROW_W-1:0];
                default:         ;
            endcase
        end
    end

    // read-modify-write: address the element on the read cycle, write it next
    assign prod = 16'($signed(act_reg) * $signed(wrow_reg[rd_idx_reg[POS_W-1:0]]));

    always_comb
    begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        row_cnt_next = row_cnt_reg;
        mac_next     = mac_reg;
        emit_next    = emit_reg;
        mem_we       = 1'b0;
        mem_wa       = cnt_reg;
        mem_wd       = bias_value;
        mem_ra       = '0;
        case (state_reg)
            ST_BIAS:
            begin
                if (accept && kind == KIND_BIAS)
                begin
                    mem_we   = 1'b1;
                    cnt_next = cnt_reg + 1'b1;
                    if (cnt_reg == IDX_W'(ELEMS - 1))
                    begin
                        cnt_next     = '0;
                        row_cnt_next = '0;
                        state_next   = ST_WEIGHT;
                    end
                end
            end
            ST_WEIGHT:
            begin
                if (accept && kind == KIND_WEIGHT)
                begin
                    cnt_next = cnt_reg + 1'b1;
                    if (cnt_reg == IDX_W'(TILE - 1))
                    begin
                        cnt_next   = '0;
                        state_next = ST_ACT;
                    end
                end
            end
            ST_ACT:
            begin
                if (accept && kind == KIND_ACT)
                begin
                    mac_next   = '0;
                    state_next = ST_MAC;
                end
            end
            ST_MAC:
            begin
                mem_ra   = IDX_W'({arow_reg, mac_reg[POS_W-1:0]});
                mem_we   = rd_vld_reg;
                mem_wa   = rd_idx_reg;
                mem_wd   = mem_rd + {{16{prod[15]}}, prod};
                mac_next = mac_reg + 1'b1;
                if (mac_reg == (POS_W+1)'(TILE))
                begin
                    mem_ra   = '0;
                    mac_next = mac_reg;
                    cnt_next = cnt_reg + 1'b1;
                    state_next = ST_ACT;
                    if (cnt_reg == IDX_W'(TILE - 1))
                    begin
                        cnt_next     = '0;
                        row_cnt_next = row_cnt_reg + 1'b1;
                        state_next   = ST_WEIGHT;
                        if (row_cnt_reg + 1'b1 >= rows_eff)
                        begin
                            emit_next  = '0;
                            state_next = ST_EMIT;
                        end
                    end
                end
            end
            ST_EMIT:
            begin
                mem_ra    = emit_reg[IDX_W-1:0];
                emit_next = emit_reg + 1'b1;
                if (emit_reg == (IDX_W+1)'(ELEMS - 1))
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (drain_reg == 4'd0 && !rd_vld_reg)
                begin
                    row_cnt_next = '0;
                    state_next   = ST_BIAS;
                end
            end
            default:
            begin
                state_next = ST_BIAS;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_BIAS;
            cnt_reg     <= '0;
            row_cnt_reg <= '0;
            mac_reg     <= '0;
            emit_reg    <= '0;
            rd_vld_reg  <= 1'b0;
            drain_reg   <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            row_cnt_reg <= row_cnt_next;
            mac_reg     <= mac_next;
            emit_reg    <= emit_next;
            rd_vld_reg  <= ((state_reg == ST_MAC) && (mac_reg < (POS_W+1)'(TILE)))
                           || (state_reg == ST_EMIT);
            // hold busy until the GELU pipe has emptied
            drain_reg   <= (state_reg == ST_EMIT) ? 4'd8
                           : ((drain_reg != 4'd0) ? drain_reg - 1'b1 : 4'd0);
        end
    end

    always_ff @(posedge clk)
    begin
        rd_idx_reg <= mem_ra;
        if (accept && state_reg == ST_WEIGHT && kind == KIND_WEIGHT)
        begin
            wrow_reg[cnt_reg[POS_W-1:0]] <= data_byte;
        end
        if (accept && state_reg == ST_ACT && kind == KIND_ACT)
        begin
            act_reg  <= data_byte;
            arow_reg <= cnt_reg[POS_W-1:0];
        end
    end

    tmg_ram #(.WIDTH(32), .DEPTH(ELEMS)) u_acc_ram (
        .clk     (clk),
        .wr_en   (mem_we),
        .wr_addr (mem_wa),
        .wr_data (mem_wd),
        .rd_addr (mem_ra),
        .rd_data (mem_rd)
    );

    tmg_gelu u_gelu (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .in_valid  (rd_vld_reg && state_reg != ST_MAC),
        .in_x      (mem_rd),
        .in_row    (rd_idx_reg[IDX_W-1:POS_W]),
        .in_col    (rd_idx_reg[POS_W-1:0]),
        .in_last   (rd_idx_reg == IDX_W'(ELEMS - 1)),
        .out_valid (g_valid),
        .out_value (out_value),
        .out_row   (g_row),
        .out_col   (g_col),
        .out_last  (g_last)
    );

    assign out_valid = g_valid;
    assign out_row   = 3'(g_row);
    assign out_col   = 3'(g_col);
    assign last      = g_valid && g_last;

    `TMG_ASSERT_IMPL(a_no_accept_busy, clk, rst_n, (state_reg == ST_MAC) |-> busy, "busy low during update")
    `TMG_ASSERT_NEXT(a_emit_drain, clk, rst_n, (state_reg == ST_EMIT) && (emit_reg == (IDX_W+1)'(ELEMS - 1)), state_reg == ST_DRAIN, "emit did not drain")
    `TMG_ASSERT_IMPL(a_out_busy, clk, rst_n, out_valid |-> busy, "result while idle")
endmodule
`default_nettype wire

>>> hw/rtl/tmg_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`default_nettype none
module tmg_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end
endmodule
`default_nettype wire

>>> hw/rtl/tmg_gelu.sv
// Pipelined integer GELU and int8 requantization of one accumulator per cycle.
// Depends on tmg_pkg and the assertion macro header.
`default_nettype none
`include "tiled_int8_matmul_gelu_core_defines.svh"
module tmg_gelu
    import tmg_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire gelu_cfg_t   cfg,
    input  wire logic        in_valid,
    input  wire logic [31:0] in_x,
    input  wire logic [POS_W-1:0] in_row,
    input  wire logic [POS_W-1:0] in_col,
    input  wire logic        in_last,
    output logic             out_valid,
    output logic [7:0]       out_value,
    output logic [POS_W-1:0] out_row,
    output logic [POS_W-1:0] out_col,
    output logic             out_last
);
    localparam int STAGES = 7;
    localparam int TAG_W  = 2 * POS_W + 1;

    logic [STAGES-1:0] vld_reg;
    logic [TAG_W-1:0]  tag_reg [STAGES];

    // stage 1: clip
    logic [31:0] x1_reg, t1_reg;
    logic        n1_reg;
    // stage 2: square
    logic [31:0] x2_reg, sq2_reg;
    logic        n2_reg;
    // stage 3: offset, sign, divide
    logic [31:0] x3_reg, g3_reg;
    // stage 4: multiply by x
    logic [31:0] v4_reg;
    // stage 5: magnitude
    logic [31:0] m5_reg;
    logic        n5_reg;
    // stage 6: scale multiply
    logic [63:0] p6_reg;
    logic        n6_reg;
    // stage 7: shift, saturate
    logic [7:0]  q7_reg;

    logic [31:0] a_abs, negb, a_clip, y_pos, y_sgn, y_div, v_mag;
    logic [63:0] p_sh;

    always_comb
    begin
        a_abs  = in_x[31] ? (32'd0 - in_x) : in_x;
        negb   = 32'd0 - cfg.gelu_b;
        a_clip = ($signed(negb) < $signed(a_abs)) ? negb : a_abs;
        y_pos  = sq2_reg + cfg.gelu_c;
        y_sgn  = n2_reg ? (32'd0 - y_pos) : y_pos;
        // truncate toward zero: bias negatives before the arithmetic shift
        y_div  = 32'($signed(y_sgn + (y_sgn[31] ? 32'd16383 : 32'd0)) >>> 14);
        v_mag  = v4_reg[31] ? (32'd0 - v4_reg) : v4_reg;
        p_sh   = p6_reg >> cfg.scale_shift;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= {vld_reg[STAGES-2:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        tag_reg[0] <= {in_row, in_col, in_last};
        for (int k = 1; k < STAGES; k++)
        begin
            tag_reg[k] <= tag_reg[k-1];
        end
        x1_reg  <= in_x;
        n1_reg  <= in_x[31];
        t1_reg  <= a_clip + cfg.gelu_b;
        x2_reg  <= x1_reg;
        n2_reg  <= n1_reg;
        sq2_reg <= 32'(t1_reg * t1_reg);
        x3_reg  <= x2_reg;
        g3_reg  <= y_div + cfg.gelu_shift;
        v4_reg  <= 32'(x3_reg * g3_reg);
        m5_reg  <= v_mag;
        n5_reg  <= v4_reg[31];
        p6_reg  <= {32'd0, m5_reg} * {32'd0, cfg.scale_mult};
        n6_reg  <= n5_reg;
        if (n6_reg)
        begin
            q7_reg <= (p_sh >= 64'd128) ? 8'h80 : 8'(64'd0 - p_sh);
        end
        else
        begin
            q7_reg <= (p_sh >= 64'd127) ? 8'h7F : p_sh[7:0];
        end
    end

    assign out_valid = vld_reg[STAGES-1];
    assign out_value = q7_reg;
    assign {out_row, out_col, out_last} = tag_reg[STAGES-1];

    `TMG_ASSERT_NEXT(a_pipe_adv, clk, rst_n, in_valid, vld_reg[0], "gelu pipe lost an entry")
    `TMG_ASSERT_IMPL(a_last_valid, clk, rst_n, (out_last && !out_valid) |-> 1'b1 || !out_last || out_valid, "tag check")
    `TMG_ASSERT_NEXT(a_idle_drain, clk, rst_n, (vld_reg == '0) && !in_valid, !out_valid, "output without entry")
endmodule
`default_nettype wire

>>> tb/tiled_int8_matmul_gelu_core_tb.sv
// Self-checking testbench for tiled_int8_matmul_gelu_core: streams bias, weight and
// activation tiles, predicts every GELU result in-bench and compares on out_valid.
// Depends on tmg_pkg and the core RTL only.
`default_nettype none
module tiled_int8_matmul_gelu_core_tb
    import tmg_pkg::*;
();

    localparam logic [1:0] KIND_NONE = 2'd3;   // never valid in any phase
    localparam int SETTLE = 24;                // cycles for the core to go quiet

    typedef struct {
        logic [7:0] value;
        logic [2:0] row;
        logic [2:0] col;
        logic       last;
    } tile_out_t;

    // One directed tile: register values, uniform operands, optional known result
    typedef struct {
        logic [31:0] regs [6];
        logic [31:0] bias;
        logic [7:0]  wb;
        logic [7:0]  ab;
        int          act_rows;
        bit          lower_mid;
        bit          known;
        logic [7:0]  known_val;
    } tile_plan_t;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic [1:0]  kind;
    logic [31:0] bias_value;
    logic [7:0]  data_byte;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [2:0]  cfg_index;
    logic [31:0] cfg_data;
    logic        out_valid;
    logic [7:0]  out_value;
    logic [2:0]  out_row;
    logic [2:0]  out_col;
    logic        last;

    tiled_int8_matmul_gelu_core uut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .kind(kind), .bias_value(bias_value), .data_byte(data_byte),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
        .cfg_data(cfg_data), .out_valid(out_valid), .out_value(out_value),
        .out_row(out_row), .out_col(out_col), .last(last)
    );

    // Mirror of the core's registers and tile state
    logic [31:0] m_gelu_b, m_gelu_c, m_gelu_shift, m_scale_mult;
    logic [5:0]  m_scale_shift;
    logic [12:0] m_inner_rows;
    logic [31:0] m_acc [ELEMS];
    logic [7:0]  m_weights [TILE];
    logic [1:0]  m_phase;
    int          m_elem;
    int          m_rows_done;

    tile_out_t   expected_tile_out [$];
    bit          fixed_en;
    logic [7:0]  fixed_val;
    int          idle_pct;
    int          mismatches;
    int          items_sent;

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Hard stop in case the core hangs
    initial
    begin
        #8000000;
        $display("tiled_int8_matmul_gelu_core verification failed");
        $finish;
    end

    // i-GELU in 32-bit wrapping arithmetic, then requantisation with a 64-bit scale product
    function automatic logic [7:0] gelu_requant(input logic [31:0] x);
        logic [31:0] a, negb, t, y, g, v, mag32;
        logic [63:0] mag;
        int          q;
        bit          neg;
        begin
            neg  = x[31];
            a    = neg ? -x : x;
            negb = -m_gelu_b;
            if ($signed(negb) < $signed(a))
                a = negb;
            t = a + m_gelu_b;
            y = t * t + m_gelu_c;
            if (neg)
                y = -y;
            q = $signed(y) / 16384;
            g = q;
            v = x * (g + m_gelu_shift);
            neg   = v[31];
            mag32 = neg ? -v : v;
            mag   = ({32'd0, mag32} * {32'd0, m_scale_mult}) >> m_scale_shift;
            if (neg)
                gelu_requant = (mag >= 64'd128) ? 8'h80 : 8'(-mag[7:0]);
            else
                gelu_requant = (mag >= 64'd127) ? 8'h7F : mag[7:0];
        end
    endfunction

    // Advance the mirrored tile state by one accepted transaction
    task automatic predict_tile(input logic [1:0] k, input logic [31:0] bv,
                                input logic [7:0] db);
        int        eff_rows;
        tile_out_t r;
        begin
            if (m_phase == KIND_BIAS)
            begin
                if (k != KIND_BIAS)
                    return;
                m_acc[m_elem] = bv;
                m_elem++;
                if (m_elem >= ELEMS)
                begin
                    m_elem      = 0;
                    m_rows_done = 0;
                    m_phase     = KIND_WEIGHT;
                end
            end
            else if (m_phase == KIND_WEIGHT)
            begin
                if (k != KIND_WEIGHT)
                    return;
                m_weights[m_elem] = db;
                m_elem++;
                if (m_elem >= TILE)
                begin
                    m_elem  = 0;
                    m_phase = KIND_ACT;
                end
            end
            else
            begin
                if (k != KIND_ACT)
                    return;
                for (int j = 0; j < TILE; j++)
                    m_acc[m_elem*TILE + j] += 32'($signed(db) * $signed(m_weights[j]));
                m_elem++;
                if (m_elem < TILE)
                    return;
                m_elem = 0;
                m_rows_done++;
                // A length of zero acts as one; anything over the maximum is clamped
                eff_rows = (m_inner_rows == 0) ? 1 :
                           (m_inner_rows > MAX_ROWS) ? int'(MAX_ROWS) : int'(m_inner_rows);
                if (m_rows_done < eff_rows)
                begin
                    m_phase = KIND_WEIGHT;
                    return;
                end
                for (int e = 0; e < ELEMS; e++)
                begin
                    r.value = fixed_en ? fixed_val : gelu_requant(m_acc[e]);
                    r.row   = 3'(e / TILE);
                    r.col   = 3'(e % TILE);
                    r.last  = (e == ELEMS - 1);
                    expected_tile_out.push_back(r);
                end
                m_rows_done = 0;
                m_phase     = KIND_BIAS;
            end
        end
    endtask

    // Compare each strobed result with the oldest expectation
    always @(posedge clk)
    begin
        tile_out_t e;
        if (rst_n && out_valid)
        begin
            if (expected_tile_out.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result value=%h row=%0d col=%0d last=%0d",
                             out_value, out_row, out_col, last);
            end
            else
            begin
                e = expected_tile_out.pop_front();
                if (e.value !== out_value || e.row !== out_row || e.col !== out_col ||
                    e.last !== last)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch exp v=%h r=%0d c=%0d l=%0d got v=%h r=%0d c=%0d l=%0d",
                                 e.value, e.row, e.col, e.last,
                                 out_value, out_row, out_col, last);
                end
            end
        end
    end

    // Hold until every expected result has left, then let the core settle
    task automatic wait_quiet();
        begin
            while (expected_tile_out.size() != 0)
                @(posedge clk);
            repeat (SETTLE) @(posedge clk);
        end
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
        begin
            cfg_valid <= 1'b1;
            cfg_index <= idx;
            cfg_data  <= val;
            do @(posedge clk); while (!cfg_ready);
            case (idx)
                REG_GELU_B:      m_gelu_b      = val;
                REG_GELU_C:      m_gelu_c      = val;
                REG_GELU_SHIFT:  m_gelu_shift  = val;
                REG_SCALE_MULT:  m_scale_mult  = val;
                REG_SCALE_SHIFT: m_scale_shift = val[5:0];
                REG_INNER_ROWS:  m_inner_rows  = val[12:0];
                default: ;
            endcase
            cfg_valid <= 1'b0;
        end
    endtask

    task automatic write_all(input logic [31:0] regs [6]);
        begin
            write_reg(REG_GELU_B, regs[0]);
            write_reg(REG_GELU_C, regs[1]);
            write_reg(REG_GELU_SHIFT, regs[2]);
            write_reg(REG_SCALE_MULT, regs[3]);
            write_reg(REG_SCALE_SHIFT, regs[4]);
            write_reg(REG_INNER_ROWS, regs[5]);
        end
    endtask

    // Drive one item; it is a transaction at the first edge with busy low
    task automatic send_item(input logic [1:0] k, input logic [31:0] bv,
                             input logic [7:0] db);
        begin
            if ($urandom_range(99) < idle_pct)
            begin
                start <= 1'b0;
                repeat ($urandom_range(1, 4)) @(posedge clk);
            end
            start      <= 1'b1;
            kind       <= k;
            bias_value <= bv;
            data_byte  <= db;
            do @(posedge clk); while (busy);
            predict_tile(k, bv, db);
            if (k != KIND_NONE)
                items_sent++;
        end
    endtask

    // Occasionally slip in an item the current phase must drop
    task automatic maybe_noise(input int pct, input logic [1:0] good);
        logic [1:0] k;
        begin
            if ($urandom_range(99) < pct)
            begin
                do k = 2'($urandom_range(3)); while (k == good);
                send_item(k, $urandom, 8'($urandom));
            end
        end
    endtask

    task automatic run_tile(input bit rnd, input logic [31:0] bias, input logic [7:0] wb,
                            input logic [7:0] ab, input int act_rows, input bit lower_mid,
                            input int noise);
        begin
            for (int e = 0; e < ELEMS; e++)
            begin
                maybe_noise(noise, KIND_BIAS);
                send_item(KIND_BIAS, rnd ? 32'($urandom) : bias, 8'($urandom));
            end
            for (int r = 0; r < act_rows; r++)
            begin
                // Lower the length once a row is done, so the next row ends the tile
                if (lower_mid && r == 1)
                begin
                    start <= 1'b0;
                    wait_quiet();
                    write_reg(REG_INNER_ROWS, 32'd1);
                end
                for (int j = 0; j < TILE; j++)
                begin
                    maybe_noise(noise, KIND_WEIGHT);
                    send_item(KIND_WEIGHT, $urandom, rnd ? 8'($urandom) : wb);
                end
                for (int i = 0; i < TILE; i++)
                begin
                    maybe_noise(noise, KIND_ACT);
                    send_item(KIND_ACT, $urandom, rnd ? 8'($urandom) : ab);
                end
            end
            start <= 1'b0;
        end
    endtask

    tile_plan_t plan [2];

    initial
    begin
        logic [31:0] regs [6];
        int          rows;

        rst_n      = 1'b0;
        start      = 1'b0;
        kind       = KIND_BIAS;
        bias_value = '0;
        data_byte  = '0;
        cfg_valid  = 1'b0;
        cfg_index  = REG_GELU_B;
        cfg_data   = '0;
        mismatches = 0;
        items_sent = 0;
        idle_pct   = 18;
        fixed_en   = 1'b0;
        fixed_val  = '0;
        m_gelu_b = '0; m_gelu_c = '0; m_gelu_shift = '0; m_scale_mult = '0;
        m_scale_shift = '0;
        m_inner_rows  = 13'd8;
        m_phase = KIND_BIAS; m_elem = 0; m_rows_done = 0;

        // Directed tiles: identity GELU saturates high with a length of zero
        // acting as one; the most negative accumulator under a length above
        // the maximum, lowered mid-tile so the second row ends the tile
        plan[0] = '{'{0, 0, 1, 1, 0, 0}, 32'h7FFF_FFFF, 8'h00, 8'h00, 1, 0, 1, 8'h7F};
        plan[1] = '{'{0, 0, 1, 1, 0, 32'h1FFF}, 32'h8000_0000, 8'h00, 8'h00, 2, 1, 0,
                    8'h00};

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Walk the directed table
        foreach (plan[p])
        begin
            write_all(plan[p].regs);
            fixed_en  = plan[p].known;
            fixed_val = plan[p].known_val;
            run_tile(1'b0, plan[p].bias, plan[p].wb, plan[p].ab, plan[p].act_rows,
                     plan[p].lower_mid, 0);
            wait_quiet();
            fixed_en = 1'b0;
        end

        // Random tiles under random settings; the second runs with no idling
        for (int n = 0; items_sent < 300; n++)
        begin
            case ($urandom_range(3))
                0: regs[0] = 32'h8000_0001;
                1: regs[0] = 32'h0;
                default: regs[0] = -32'($urandom_range(1, 1 << 24));
            endcase
            regs[1] = $urandom;
            regs[2] = $urandom_range(1) ? 32'($signed($urandom_range(0, 64)) - 32) : $urandom;
            regs[3] = $urandom_range(1) ? 32'($urandom_range(1, 1 << 16)) : $urandom;
            regs[4] = $urandom_range(63);
            rows    = $urandom_range(1, 3);
            regs[5] = rows;
            write_all(regs);
            idle_pct = (n == 1) ? 0 : 18;
            run_tile(1'b1, '0, '0, '0, rows, 1'b0, 8);
            wait_quiet();
        end

        while (expected_tile_out.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
        if (mismatches == 0)
            $display("tiled_int8_matmul_gelu_core verification clean");
        else
            $display("tiled_int8_matmul_gelu_core verification failed");
        $finish;
    end
endmodule
`default_nettype wire
